### src/afbf_pkg.sv
// afbf_pkg: shared types, codes and text mask helpers for the prefix filter
// used by afbf_ctrl, afbf_dp and the top level; no dependencies
package afbf_pkg;

	localparam int MAX_CHARS   = 15;
	localparam int TEXT_HIGH_W = 64;
	localparam int TEXT_LOW_W  = 56;
	localparam int LEN_W       = 4;

	// action codes
	localparam logic [1:0] ACT_ADD          = 2'd0;
	localparam logic [1:0] ACT_QUERY_ACTIVE = 2'd1;
	localparam logic [1:0] ACT_QUERY_SELECT = 2'd2;

	// list type codes
	localparam logic [1:0] LT_ALLOW_ALL    = 2'd0;
	localparam logic [1:0] LT_ALLOW_LISTED = 2'd1;
	localparam logic [1:0] LT_BLOCK_LISTED = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_LEN = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// config register indexes
	localparam logic [1:0] CFG_ACTIVE_LIST  = 2'd0;
	localparam logic [1:0] CFG_SERVICE_TYPE = 2'd1;
	localparam logic [1:0] CFG_CHECK_TYPE   = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK,
		S_REPLY
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic walk;
	} afbf_cmd_t;

	typedef struct packed {
		logic need_walk;
		logic walk_done;
	} afbf_stat_t;

	typedef struct packed {
		logic [TEXT_HIGH_W-1:0] high;
		logic [TEXT_LOW_W-1:0]  low;
		logic [LEN_W-1:0]       size;
	} entry_t;

	// keeps the first n characters of the high word
	function automatic logic [TEXT_HIGH_W-1:0] high_mask(input logic [LEN_W-1:0] n);
		logic [TEXT_HIGH_W-1:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (LEN_W'(b) < n) begin
				m[TEXT_HIGH_W-1-8*b -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	// keeps characters 9 to n of the low word
	function automatic logic [TEXT_LOW_W-1:0] low_mask(input logic [LEN_W-1:0] n);
		logic [TEXT_LOW_W-1:0] m;
		m = '0;
		for (int b = 0; b < 7; b++) begin
			if (LEN_W'(b + 8) < n) begin
				m[TEXT_LOW_W-1-8*b -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

endpackage

### src/afbf_ctrl.sv
// afbf_ctrl: sequencing state machine for the prefix filter
// depends on afbf_pkg; drives afbf_dp through command and status structs
module afbf_ctrl
	import afbf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  afbf_stat_t stat,
	output afbf_cmd_t  cmd,
	output logic       busy,
	output logic       done
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		busy       = 1'b1;
		done       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.need_walk ? S_WALK : S_REPLY;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_done) begin
					state_d = S_REPLY;
				end
			end
			S_REPLY: begin
				done    = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### src/afbf_dp.sv
// afbf_dp: config registers, entry memory, fill counters and prefix compare
// depends on afbf_pkg; sequenced by afbf_ctrl
module afbf_dp
	import afbf_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  afbf_cmd_t              cmd,
	output afbf_stat_t             stat,
	input  logic [1:0]             action,
	input  logic                   list_select,
	input  logic [TEXT_HIGH_W-1:0] text_high,
	input  logic [TEXT_LOW_W-1:0]  text_low,
	input  logic [LEN_W-1:0]       text_length,
	input  logic                   cfg_write,
	input  logic [1:0]             cfg_index,
	input  logic [1:0]             cfg_data,
	output logic                   allowed,
	output logic [1:0]             status,
	output logic                   prefix_hit
);

	localparam int FW    = $clog2(ENTRIES + 1);
	localparam int AW    = $clog2(2 * ENTRIES);
	localparam int DEPTH = 2 * ENTRIES;

	logic       active_list_q;
	logic [1:0] service_type_q;
	logic [1:0] check_type_q;

	logic [1:0]             act_q;
	logic                   list_q;
	logic [TEXT_HIGH_W-1:0] th_q;
	logic [TEXT_LOW_W-1:0]  tl_q;
	logic [LEN_W-1:0]       len_q;

	logic [FW-1:0] fill_q [2];
	logic [FW-1:0] idx_q;
	logic          pend_q;
	entry_t        rd_q;
	entry_t        mem [DEPTH];

	logic       allowed_q;
	logic [1:0] status_q;
	logic       hit_q;

	logic [1:0]    type_sel;
	logic [FW-1:0] fill_sel;
	logic [AW-1:0] base_addr;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	logic          bad_len;
	logic          is_query;
	logic          add_ok;
	logic          mem_we;
	logic          issue;
	logic          match;
	logic          hit_now;
	logic          last;
	logic          need_walk;
	logic          walk_done;
	logic          dec_allowed;
	logic [1:0]    dec_status;
	entry_t        wr_entry;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_list_q  <= 1'b0;
			service_type_q <= LT_ALLOW_ALL;
			check_type_q   <= LT_ALLOW_ALL;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_ACTIVE_LIST:  active_list_q  <= cfg_data[0];
				CFG_SERVICE_TYPE: service_type_q <= cfg_data;
				CFG_CHECK_TYPE:   check_type_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// latch the input word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			list_q <= (action == ACT_QUERY_ACTIVE) ? active_list_q : list_select;
			th_q   <= text_high;
			tl_q   <= text_low;
			len_q  <= text_length;
		end
	end

	assign type_sel  = list_q ? check_type_q : service_type_q;
	assign fill_sel  = fill_q[list_q];
	assign base_addr = list_q ? AW'(ENTRIES) : '0;
	assign wr_addr   = base_addr + AW'(fill_sel);
	assign rd_addr   = base_addr + AW'(idx_q);
	assign bad_len   = (len_q == '0) || (32'(len_q) > MAX_CHARS);
	assign is_query  = (act_q == ACT_QUERY_ACTIVE) || (act_q == ACT_QUERY_SELECT);
	assign add_ok    = (act_q == ACT_ADD) && !bad_len && (fill_sel != FW'(ENTRIES));
	assign mem_we    = cmd.decide && add_ok;

	always_comb begin
		wr_entry.high = th_q & high_mask(len_q);
		wr_entry.low  = tl_q & low_mask(len_q);
		wr_entry.size = len_q;
	end

	// verdict for everything that needs no walk
	always_comb begin
		dec_allowed = 1'b0;
		dec_status  = ST_OK;
		need_walk   = 1'b0;
		if (act_q == ACT_ADD) begin
			priority if (bad_len) begin
				dec_status = ST_BAD_LEN;
			end else if (fill_sel == FW'(ENTRIES)) begin
				dec_status = ST_FULL;
			end else begin
				dec_status = ST_OK;
			end
		end else if (is_query) begin
			priority if (type_sel == LT_ALLOW_ALL || fill_sel == '0) begin
				dec_allowed = 1'b1;
			end else if (bad_len) begin
				dec_status = ST_BAD_LEN;
			end else if (type_sel == LT_ALLOW_LISTED || type_sel == LT_BLOCK_LISTED) begin
				need_walk = 1'b1;
			end else begin
				// reserved list type: deny without a walk
				dec_allowed = 1'b0;
			end
		end
	end

	// walk: one memory read per cycle, compare on the registered word
	assign match     = (rd_q.size <= len_q)
	                 && ((th_q & high_mask(rd_q.size)) == rd_q.high)
	                 && ((tl_q & low_mask(rd_q.size)) == rd_q.low);
	assign hit_now   = pend_q && match;
	assign last      = (idx_q == fill_sel);
	assign issue     = cmd.walk && !hit_now && !last;
	assign walk_done = cmd.walk && (hit_now || last);
	assign stat      = {need_walk, walk_done};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_entry;
		end
		if (issue) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q[0] <= '0;
			fill_q[1] <= '0;
			idx_q     <= '0;
			pend_q    <= 1'b0;
		end else begin
			pend_q <= issue;
			if (mem_we) begin
				fill_q[list_q] <= fill_sel + FW'(1);
			end
			if (cmd.decide) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + FW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			allowed_q <= dec_allowed;
			status_q  <= dec_status;
			hit_q     <= 1'b0;
		end else if (walk_done) begin
			allowed_q <= (type_sel == LT_ALLOW_LISTED) ? hit_now : !hit_now;
			status_q  <= ST_OK;
			hit_q     <= hit_now;
		end
	end

	assign allowed    = allowed_q;
	assign status     = status_q;
	assign prefix_hit = hit_q;

endmodule

### src/address_prefix_allow_block_filter_top.sv
// adds, trivial queries and unused actions go from idle through decide to reply, which strobes done
// a walked query walks the list from entry 0 between decide and reply, stopping at the first hit
// or after the last entry with no hit; the entry memory reads one entry a cycle during the walk
// throughput: one word at a time, next start taken the cycle after done
// reset clears the fill counts, the config registers and the controller; the
// entry memory is not cleared; results cannot be stalled
module address_prefix_allow_block_filter_top
	import afbf_pkg::*;
#(
	parameter int ENTRIES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [1:0]             action,
	input  logic                   list_select,
	input  logic [TEXT_HIGH_W-1:0] text_high,
	input  logic [TEXT_LOW_W-1:0]  text_low,
	input  logic [LEN_W-1:0]       text_length,
	input  logic                   cfg_write,
	input  logic [1:0]             cfg_index,
	input  logic [1:0]             cfg_data,
	output logic                   done,
	output logic                   allowed,
	output logic [1:0]             status,
	output logic                   prefix_hit
);

	afbf_cmd_t  cmd;
	afbf_stat_t stat;

	afbf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	afbf_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (action),
		.list_select (list_select),
		.text_high   (text_high),
		.text_low    (text_low),
		.text_length (text_length),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.allowed     (allowed),
		.status      (status),
		.prefix_hit  (prefix_hit)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not make the block busy");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy period");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> !allowed && !prefix_hit)
		else $error("error status with allow or hit set");

endmodule

### tb/sv/tb_top.sv
// tb_top: self-checking bench for the prefix-match allow/block filter
// sends words through start/busy, writes the config port and predicts every verdict
// depends on afbf_pkg and address_prefix_allow_block_filter_top
module tb_top;
	import afbf_pkg::*;

	localparam int ENTRIES = 64;
	localparam int TEXT_W = TEXT_HIGH_W + TEXT_LOW_W;
	localparam int PHASES = 8;
	localparam int PHASE_WORDS = 212;
	localparam int STALL_LIMIT = 2000;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [1:0] LT_RESERVED = 2'd3;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic              sel;
		logic [TEXT_W-1:0] text;
		logic [LEN_W-1:0]  len;
	} acl_word_t;

	typedef struct packed {
		logic       allowed;
		logic [1:0] status;
		logic       hit;
	} verdict_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start = 1'b0;
	logic                   busy;
	logic [1:0]             action = '0;
	logic                   list_select = 1'b0;
	logic [TEXT_HIGH_W-1:0] text_high = '0;
	logic [TEXT_LOW_W-1:0]  text_low = '0;
	logic [LEN_W-1:0]       text_length = '0;
	logic                   cfg_write = 1'b0;
	logic [1:0]             cfg_index = '0;
	logic [1:0]             cfg_data = '0;
	logic                   done;
	logic                   allowed;
	logic [1:0]             status;
	logic                   prefix_hit;

	// shadow of the block's registers and both lists
	logic              act_list = 1'b0;
	logic [1:0]        svc_type = LT_ALLOW_ALL;
	logic [1:0]        chk_type = LT_ALLOW_ALL;
	logic [TEXT_W-1:0] stored_text [2][ENTRIES];
	logic [LEN_W-1:0]  stored_len [2][ENTRIES];
	int                fill [2] = '{0, 0};

	verdict_t pending_verdicts [$];
	int       errors = 0;
	int       stall_cycles = 0;

	address_prefix_allow_block_filter_top #(
		.ENTRIES(ENTRIES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.action(action),
		.list_select(list_select),
		.text_high(text_high),
		.text_low(text_low),
		.text_length(text_length),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.allowed(allowed),
		.status(status),
		.prefix_hit(prefix_hit)
	);

	always #5 clk = ~clk;

	// top n characters of the joined high/low text
	function automatic logic [TEXT_W-1:0] char_mask(input logic [LEN_W-1:0] n);
		return ~({TEXT_W{1'b1}} >> (8 * n));
	endfunction

	function automatic logic [TEXT_W-1:0] text_of(input string s);
		logic [TEXT_W-1:0] t;
		t = '0;
		for (int k = 0; k < s.len(); k++) begin
			t[TEXT_W-1-8*k -: 8] = s[k];
		end
		return t;
	endfunction

	// characters from a four-letter alphabet so prefixes collide often
	function automatic logic [TEXT_W-1:0] grow_text(input logic [TEXT_W-1:0] base,
			input int from, input int upto);
		logic [TEXT_W-1:0] t;
		t = base;
		for (int k = from; k < upto; k++) begin
			t[TEXT_W-1-8*k -: 8] = 8'h61 + 8'($urandom_range(0, 3));
		end
		return t;
	endfunction

	function automatic logic [TEXT_W-1:0] rand_text();
		logic [127:0] r;
		r = {$urandom, $urandom, $urandom, $urandom};
		return r[TEXT_W-1:0];
	endfunction

	function automatic acl_word_t word_of(input logic [1:0] act, input logic sel,
			input logic [TEXT_W-1:0] text, input logic [LEN_W-1:0] len);
		acl_word_t w;
		w.action = act;
		w.sel = sel;
		w.text = text;
		w.len = len;
		return w;
	endfunction

	function automatic verdict_t predict_verdict(input acl_word_t w);
		verdict_t   v;
		int         lst;
		logic [1:0] ltype;
		logic       found;
		v = '0;
		case (w.action)
			ACT_ADD: begin
				if (w.len == 0) begin
					v.status = ST_BAD_LEN;
				end else if (fill[w.sel] >= ENTRIES) begin
					v.status = ST_FULL;
				end else begin
					stored_text[w.sel][fill[w.sel]] = w.text & char_mask(w.len);
					stored_len[w.sel][fill[w.sel]] = w.len;
					fill[w.sel]++;
				end
			end
			ACT_QUERY_ACTIVE, ACT_QUERY_SELECT: begin
				lst = (w.action == ACT_QUERY_ACTIVE) ? int'(act_list) : int'(w.sel);
				ltype = (lst == 0) ? svc_type : chk_type;
				if (ltype == LT_ALLOW_ALL || fill[lst] == 0) begin
					v.allowed = 1'b1;
				end else if (w.len == 0) begin
					v.status = ST_BAD_LEN;
				end else if (ltype == LT_ALLOW_LISTED || ltype == LT_BLOCK_LISTED) begin
					found = 1'b0;
					// an entry longer than the query never matches
					for (int i = 0; i < fill[lst] && !found; i++) begin
						if (stored_len[lst][i] <= w.len &&
								(w.text & char_mask(stored_len[lst][i])) == stored_text[lst][i])
							found = 1'b1;
					end
					v.hit = found;
					v.allowed = (ltype == LT_ALLOW_LISTED) ? found : !found;
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic acl_word_t random_word();
		acl_word_t        w;
		int               pick;
		int               lst;
		int               idx;
		logic [LEN_W-1:0] base;
		pick = $urandom_range(0, 99);
		w.sel = 1'($urandom_range(0, 1));
		if (pick < 14) begin
			w.action = ACT_ADD;
			w.len = ($urandom_range(0, 9) < 3) ? 4'($urandom_range(0, 15)) :
				4'($urandom_range(2, 7));
			w.text = grow_text('0, 0, w.len);
		end else if (pick < 84) begin
			w.action = $urandom_range(0, 1) ? ACT_QUERY_ACTIVE : ACT_QUERY_SELECT;
			lst = (w.action == ACT_QUERY_ACTIVE) ? int'(act_list) : int'(w.sel);
			if (fill[lst] != 0 && $urandom_range(0, 9) < 6) begin
				// extend a stored entry so the walk finds it
				idx = $urandom_range(0, fill[lst] - 1);
				base = stored_len[lst][idx];
				w.len = 4'($urandom_range(base, 15));
				w.text = grow_text(stored_text[lst][idx], base, w.len);
			end else begin
				w.len = 4'($urandom_range(1, 15));
				w.text = grow_text('0, 0, w.len);
			end
		end else begin
			w.action = 2'($urandom_range(0, 3));
			w.len = 4'($urandom_range(0, 15));
			w.text = rand_text();
			return w;
		end
		// junk past the length must not matter
		if ($urandom_range(0, 3) == 0)
			w.text = w.text | (rand_text() & ~char_mask(w.len));
		return w;
	endfunction

	function automatic logic [1:0] pick_type();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return LT_ALLOW_LISTED;
		else if (r < 8)
			return LT_BLOCK_LISTED;
		else if (r < 9)
			return LT_ALLOW_ALL;
		return LT_RESERVED;
	endfunction

	task automatic send_word(input acl_word_t w);
		@(negedge clk);
		start <= 1'b1;
		action <= w.action;
		list_select <= w.sel;
		{text_high, text_low} <= w.text;
		text_length <= w.len;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_verdicts.insert(pending_verdicts.size(), predict_verdict(w));
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] data);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_ACTIVE_LIST: act_list = data[0];
			CFG_SERVICE_TYPE: svc_type = data;
			CFG_CHECK_TYPE: chk_type = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic idle_gap(input int pct);
		if ($urandom_range(1, 100) <= pct)
			repeat ($urandom_range(1, 15)) @(negedge clk);
	endtask

	// empty lists of allow-all type, unused action
	task automatic test_power_on();
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b0, '0, 4'd0));
		send_word(word_of(ACT_QUERY_SELECT, 1'b1, '1, 4'd15));
		send_word(word_of(ACT_UNUSED, 1'b1, '1, 4'd15));
	endtask

	task automatic test_add_entries();
		send_word(word_of(ACT_ADD, 1'b0, text_of("10.1"), 4'd0));
		send_word(word_of(ACT_ADD, 1'b0, text_of("10.") | ~char_mask(4'd3), 4'd3));
		send_word(word_of(ACT_ADD, 1'b0, '1, 4'd15));
		send_word(word_of(ACT_ADD, 1'b1, text_of("192.168."), 4'd8));
		send_word(word_of(ACT_ADD, 1'b1, text_of("172.16.0.5"), 4'd9));
		send_word(word_of(ACT_ADD, 1'b1, text_of("fe80::1"), 4'd7));
	endtask

	task automatic test_prefix_walk();
		wait_idle();
		write_reg(CFG_SERVICE_TYPE, LT_ALLOW_LISTED);
		write_reg(CFG_CHECK_TYPE, LT_BLOCK_LISTED);
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b1, text_of("10.0.0.7"), 4'd8));
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b1, text_of("11.0.0.7"), 4'd8));
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b0, text_of("10"), 4'd2));
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b0, '1, 4'd14));
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b0, '1, 4'd15));
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b0, text_of("10.0"), 4'd0));
		send_word(word_of(ACT_QUERY_SELECT, 1'b1, text_of("192.168.1.1"), 4'd11));
		send_word(word_of(ACT_QUERY_SELECT, 1'b1, text_of("172.16.0.99"), 4'd11));
		send_word(word_of(ACT_QUERY_SELECT, 1'b1, text_of("172.16.07"), 4'd9));
		send_word(word_of(ACT_QUERY_SELECT, 1'b1, text_of("192.168.1.1"), 4'd7));
	endtask

	// reserved list type, unused register index, active select from data bit 0
	task automatic test_type_corners();
		wait_idle();
		write_reg(CFG_ACTIVE_LIST, 2'd3);
		write_reg(CFG_CHECK_TYPE, LT_RESERVED);
		write_reg(CFG_UNUSED, 2'd2);
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b0, text_of("fe80::1:2"), 4'd9));
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b0, '0, 4'd0));
		wait_idle();
		write_reg(CFG_SERVICE_TYPE, LT_ALLOW_ALL);
		write_reg(CFG_ACTIVE_LIST, 2'd2);
		send_word(word_of(ACT_QUERY_SELECT, 1'b0, '0, 4'd0));
		send_word(word_of(ACT_QUERY_ACTIVE, 1'b1, text_of("99"), 4'd2));
	endtask

	task automatic test_random_traffic();
		int idle_pct;
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			write_reg(CFG_ACTIVE_LIST, 2'($urandom_range(0, 3)));
			write_reg(CFG_SERVICE_TYPE, pick_type());
			write_reg(CFG_CHECK_TYPE, pick_type());
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_UNUSED, 2'($urandom_range(0, 3)));
			// no idling in the last phase
			idle_pct = (p == PHASES - 1) ? 0 : 20 * $urandom_range(0, 3);
			repeat (PHASE_WORDS) begin
				send_word(random_word());
				idle_gap(idle_pct);
			end
		end
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (pending_verdicts.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("result with nothing pending: allowed=%0b status=%0d hit=%0b",
						allowed, status, prefix_hit);
			end else begin
				want = pending_verdicts.pop_front();
				if (allowed !== want.allowed || status !== want.status ||
						prefix_hit !== want.hit) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp a=%0b s=%0d h=%0b got a=%0b s=%0d h=%0b",
							want.allowed, want.status, want.hit, allowed, status, prefix_hit);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_power_on();
		test_add_entries();
		test_prefix_walk();
		test_type_corners();
		test_random_traffic();
		wait_idle();
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
